// ----- rtl/core/bti_pkg.sv -----
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and codes for the bgra tint / premultiply / luma alpha pipeline.
// ----------------------------------------------------------------------------
package bti_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TINT_ENABLE     = 3'd0,
    CFG_TINT_RED        = 3'd1,
    CFG_TINT_GREEN      = 3'd2,
    CFG_TINT_BLUE       = 3'd3,
    CFG_TRANSFORM_MODE  = 3'd4,
    CFG_ALPHA_FROM_LUMA = 3'd5
  } cfg_idx_e;

  // colour transform codes
  typedef enum logic [1:0] {
    XF_NONE    = 2'd0,
    XF_PREMUL  = 2'd1,
    XF_SQUARE  = 2'd2
  } xform_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // unity gain in q4.12
  localparam logic signed [15:0] GainUnity = 16'sd4096;

  // reciprocal of 255 for 16-bit dividends: x / 255 == (x * 0x8081) >> 23
  localparam logic [15:0] Recip255 = 16'h8081;
  localparam int unsigned Recip255Shift = 23;

  typedef struct packed {
    logic               tint_en;
    logic signed [15:0] gain_r;
    logic signed [15:0] gain_g;
    logic signed [15:0] gain_b;
    logic [1:0]         mode;
    logic               alpha_luma;
  } cfg_t;

  // raw pixel
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
    logic       last;
  } pix_t;

  // after tint multiply
  typedef struct packed {
    logic signed [23:0] pb;
    logic signed [23:0] pg;
    logic signed [23:0] pr;
    logic [7:0]         a;
    logic               last;
  } tint_t;

  // after transform multiply
  typedef struct packed {
    logic [15:0] pb;
    logic [15:0] pg;
    logic [15:0] pr;
    logic [7:0]  a;
    logic        last;
  } xform_t;

endpackage

// ----- rtl/core/bti_pix_if.sv -----
// ----------------------------------------------------------------------------
// bti_in_if / bti_out_if
// Valid/ready pixel channels for the input and result sides.
// ----------------------------------------------------------------------------
interface bti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  logic [7:0] in_alpha;
  logic       in_last;

  modport source (output valid, in_blue, in_green, in_red, in_alpha, in_last,
                  input ready);
  modport sink   (input valid, in_blue, in_green, in_red, in_alpha, in_last,
                  output ready);
endinterface

interface bti_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;
  logic       out_last;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, out_last,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, out_last,
                  output ready);
endinterface

// ----- rtl/core/bti_tint_stage.sv -----
// ----------------------------------------------------------------------------
// bti_tint_stage
// Stage 1: signed q4.12 gain multiply per colour channel.
// ----------------------------------------------------------------------------
module bti_tint_stage
  import bti_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  pix_t  pix_i,
  output logic  valid_o,
  input  logic  ready_i,
  output tint_t tint_o
);

  logic               valid_q;
  tint_t              tint_q, tint_d;
  logic signed [15:0] gb, gg, gr;
  logic signed [23:0] mb, mg, mr;

  // bypass uses unity gain so the clamp later returns the channel as is
  assign gb = cfg_i.tint_en ? cfg_i.gain_b : GainUnity;
  assign gg = cfg_i.tint_en ? cfg_i.gain_g : GainUnity;
  assign gr = cfg_i.tint_en ? cfg_i.gain_r : GainUnity;

  // a byte times a 16-bit signed gain always fits in 24 signed bits
  assign mb = $signed({1'b0, pix_i.b}) * gb;
  assign mg = $signed({1'b0, pix_i.g}) * gg;
  assign mr = $signed({1'b0, pix_i.r}) * gr;

  always_comb begin
    tint_d.pb   = mb;
    tint_d.pg   = mg;
    tint_d.pr   = mr;
    tint_d.a    = pix_i.a;
    tint_d.last = pix_i.last;
  end

  assign ready_o = !valid_q || ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      tint_q <= tint_d;
    end
  end

  assign valid_o = valid_q;
  assign tint_o  = tint_q;

endmodule

// ----- rtl/core/bti_xform_stage.sv -----
// ----------------------------------------------------------------------------
// bti_xform_stage
// Stage 2: clamp tinted channels to a byte, then premultiply, square or scale by 255.
// ----------------------------------------------------------------------------
module bti_xform_stage
  import bti_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  output logic   ready_o,
  input  tint_t  tint_i,
  output logic   valid_o,
  input  logic   ready_i,
  output xform_t xform_o
);

  logic       valid_q;
  xform_t     xform_q, xform_d;
  logic [7:0] cb, cg, cr;
  logic [7:0] fb, fg, fr;

  // negative gives zero, otherwise floor and saturate at 255
  function automatic logic [7:0] clamp_byte(input logic signed [23:0] p);
    logic [7:0] res;
    if (p[23]) begin
      res = 8'd0;
    end else if (|p[22:20]) begin
      res = 8'd255;
    end else begin
      res = p[19:12];
    end
    return res;
  endfunction

  assign cb = clamp_byte(tint_i.pb);
  assign cg = clamp_byte(tint_i.pg);
  assign cr = clamp_byte(tint_i.pr);

  // second factor; no transform multiplies by 255 so the divide is exact
  always_comb begin
    case (xform_e'(cfg_i.mode))
      XF_PREMUL: begin
        fb = tint_i.a;
        fg = tint_i.a;
        fr = tint_i.a;
      end
      XF_SQUARE: begin
        fb = cb;
        fg = cg;
        fr = cr;
      end
      default: begin
        fb = 8'd255;
        fg = 8'd255;
        fr = 8'd255;
      end
    endcase
  end

  always_comb begin
    xform_d.pb   = cb * fb;
    xform_d.pg   = cg * fg;
    xform_d.pr   = cr * fr;
    xform_d.a    = tint_i.a;
    xform_d.last = tint_i.last;
  end

  assign ready_o = !valid_q || ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      xform_q <= xform_d;
    end
  end

  assign valid_o = valid_q;
  assign xform_o = xform_q;

endmodule

// ----- rtl/core/bti_scale_stage.sv -----
// ----------------------------------------------------------------------------
// bti_scale_stage
// Stage 3: floor divide each product by 255 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bti_scale_stage
  import bti_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  xform_t xform_i,
  output logic   valid_o,
  input  logic   ready_i,
  output pix_t   pix_o
);

  logic        valid_q;
  pix_t        pix_q, pix_d;
  logic [31:0] qb, qg, qr;

  assign qb = xform_i.pb * Recip255;
  assign qg = xform_i.pg * Recip255;
  assign qr = xform_i.pr * Recip255;

  always_comb begin
    pix_d.b    = qb[Recip255Shift +: 8];
    pix_d.g    = qg[Recip255Shift +: 8];
    pix_d.r    = qr[Recip255Shift +: 8];
    pix_d.a    = xform_i.a;
    pix_d.last = xform_i.last;
  end

  assign ready_o = !valid_q || ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

// ----- rtl/core/bti_out_stage.sv -----
// ----------------------------------------------------------------------------
// bti_out_stage
// Stage 4: optional alpha from the largest colour, output register.
// ----------------------------------------------------------------------------
module bti_out_stage
  import bti_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  pix_t pix_i,
  bti_out_if.source pix_o
);

  logic       valid_q;
  pix_t       pix_q, pix_d;
  logic [7:0] max_bg, max_all;

  // largest of the three colours
  assign max_bg  = (pix_i.b > pix_i.g) ? pix_i.b : pix_i.g;
  assign max_all = (pix_i.r > max_bg) ? pix_i.r : max_bg;

  always_comb begin
    pix_d   = pix_i;
    pix_d.a = cfg_i.alpha_luma ? max_all : pix_i.a;
  end

  assign ready_o = !valid_q || pix_o.ready;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o.valid     = valid_q;
  assign pix_o.out_blue  = pix_q.b;
  assign pix_o.out_green = pix_q.g;
  assign pix_o.out_red   = pix_q.r;
  assign pix_o.out_alpha = pix_q.a;
  assign pix_o.out_last  = pix_q.last;

endmodule

// ----- rtl/core/bgra_tint_premultiply_luma_alpha_top.sv -----
// ----------------------------------------------------------------------------
// bgra_tint_premultiply_luma_alpha_top
// Per-pixel bgra tint, premultiply or square, and alpha from largest colour.
//
//   channel   dir   carries
//   pix_i     in    in_blue, in_green, in_red, in_alpha, in_last (valid/ready)
//   pix_o     out   out_blue, out_green, out_red, out_alpha, out_last
//   cfg_*     in    register index and 16-bit data, written on cfg_we_i
//
// One pixel per clock sustained while pix_o is ready; four register stages (tint
// multiply, clamp and transform multiply, divide by 255, alpha select), and
// each item passes through them in that order.
// Each stage holds while the one after it is full and stalled.
// Reset clears all valid bits and loads the register defaults (unity gains).
// ----------------------------------------------------------------------------
module bgra_tint_premultiply_luma_alpha_top
  import bti_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bti_in_if.sink              pix_i,
  bti_out_if.source           pix_o
);

  cfg_t   cfg_q;
  pix_t   in_pix;
  logic   v1, r1, v2, r2, v3, r3;
  tint_t  tint_s;
  xform_t xform_s;
  pix_t   scale_s;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tint_en    <= 1'b0;
      cfg_q.gain_r     <= GainUnity;
      cfg_q.gain_g     <= GainUnity;
      cfg_q.gain_b     <= GainUnity;
      cfg_q.mode       <= XF_NONE;
      cfg_q.alpha_luma <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TINT_ENABLE:     cfg_q.tint_en    <= cfg_data_i[0];
        CFG_TINT_RED:        cfg_q.gain_r     <= cfg_data_i;
        CFG_TINT_GREEN:      cfg_q.gain_g     <= cfg_data_i;
        CFG_TINT_BLUE:       cfg_q.gain_b     <= cfg_data_i;
        CFG_TRANSFORM_MODE:  cfg_q.mode       <= cfg_data_i[1:0];
        CFG_ALPHA_FROM_LUMA: cfg_q.alpha_luma <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input item
  always_comb begin
    in_pix.b    = pix_i.in_blue;
    in_pix.g    = pix_i.in_green;
    in_pix.r    = pix_i.in_red;
    in_pix.a    = pix_i.in_alpha;
    in_pix.last = pix_i.in_last;
  end

  bti_tint_stage u_tint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .pix_i   (in_pix),
    .valid_o (v1),
    .ready_i (r1),
    .tint_o  (tint_s)
  );

  bti_xform_stage u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (v1),
    .ready_o (r1),
    .tint_i  (tint_s),
    .valid_o (v2),
    .ready_i (r2),
    .xform_o (xform_s)
  );

  bti_scale_stage u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .xform_i (xform_s),
    .valid_o (v3),
    .ready_i (r3),
    .pix_o   (scale_s)
  );

  bti_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (v3),
    .ready_o (r3),
    .pix_i   (scale_s),
    .pix_o   (pix_o)
  );

endmodule
